@@ design/dma_controller_otc_and_linked_list_macros.svh @@
// Assertion macros shared by the DMA controller modules.
`ifndef DMA_CONTROLLER_OTC_AND_LINKED_LIST_MACROS_SVH
`define DMA_CONTROLLER_OTC_AND_LINKED_LIST_MACROS_SVH
// Check an implication every clock edge, disabled during reset.
`define DMA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Check an implication at the next clock edge, disabled during reset.
`define DMA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

@@ design/dmaotc_pkg.sv @@
// Shared types and constants of the DMA controller.
package dmaotc_pkg;
  localparam int AddrBits = 21;
  localparam int Channels = 7;
  localparam int NRegs = 30;
  localparam int QDepth = 2;

  localparam logic [31:0] PrioReset = 32'h0765_4321;
  localparam logic [31:0] BitBusy = 32'h0100_0000;
  localparam logic [31:0] BitTrig = 32'h1000_0000;
  localparam logic [31:0] CtlOtc = 32'h1100_0002;
  localparam logic [31:0] CtlList = 32'h0100_0401;
  localparam logic [31:0] CtlSeq = 32'h0100_0201;
  localparam logic [31:0] OtcEnd = 32'h00ff_ffff;
  localparam logic [31:0] HdrEnd = 32'h0080_0000;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0, CMD_READ = 2'd1, CMD_TICK = 2'd2, CMD_MEM = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    K_READ = 4'd0, K_WOK = 4'd1, K_MREQ = 4'd2, K_MWR = 4'd3, K_GPU = 4'd4,
    K_IDLE = 4'd5, K_HDR = 4'd6, K_BAD = 4'd7, K_UNEXP = 4'd8, K_BUSY = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    M_IDLE = 2'd0, M_OTC = 2'd1, M_SEQ = 2'd2, M_LIST = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] mem_data;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          kind;
    logic [AddrBits-1:0] mem_address;
    logic [31:0]         data_out;
    logic                transfer_done;
  } out_item_t;

  // Classified transaction passed from front to back.
  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  idx;
    logic        idx_ok;
    logic [31:0] wdata;
    logic [31:0] mdata;
  } op_t;
endpackage

@@ design/dma_controller_otc_and_linked_list.sv @@
// Top level of the seven-channel DMA controller.
// Each transaction (register write or read, tick, memory return) yields one result;
// a new transaction is taken every cycle while full is low, with a two-entry queue ahead
// of the engine and a one-entry result register behind it. A transaction is classified
// into the queue, and the engine registers its result in the result register, from which
// it is popped. With pop held high one transaction per cycle goes through; while pop is
// low the result holds, the queue takes two more transactions and then full rises until
// a result is popped.
module dma_controller_otc_and_linked_list (
  input  logic                  clk,
  input  logic                  rst,
  input  dmaotc_pkg::in_item_t  in_item,
  input  logic                  push,
  output logic                  full,
  output dmaotc_pkg::out_item_t out_item,
  output logic                  empty,
  input  logic                  pop
);
  import dmaotc_pkg::*;

  op_t  op;
  logic op_valid;
  logic op_take;

  dmaotc_front u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .op(op), .op_valid(op_valid), .op_take(op_take)
  );

  dmaotc_back u_back (
    .clk(clk), .rst(rst), .op(op), .op_valid(op_valid), .op_take(op_take),
    .out_item(out_item), .empty(empty), .pop(pop)
  );
endmodule

@@ design/dmaotc_front.sv @@
// Front part: accepts input transactions, classifies them and queues them.
module dmaotc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  dmaotc_pkg::in_item_t  in_item,
  input  logic                  push,
  output logic                  full,
  output dmaotc_pkg::op_t       op,
  output logic                  op_valid,
  input  logic                  op_take
);
  import dmaotc_pkg::*;

  op_t        q [QDepth];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  op_t        cls;

  // Classify the incoming transaction.
  always_comb begin
    cls.cmd = cmd_t'(in_item.cmd);
    cls.idx = in_item.reg_index;
    cls.idx_ok = in_item.reg_index < 5'(NRegs);
    cls.wdata = in_item.write_data;
    cls.mdata = in_item.mem_data;
  end

  assign full = count == 2'(QDepth);
  assign do_push = push && !full;
  assign op_valid = count != 2'd0;
  assign do_pop = op_valid && op_take;
  assign op = q[rd_ptr];

  // Store payload.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  // Advance pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  `include "dma_controller_otc_and_linked_list_macros.svh"
  `DMA_ASSERT_IMP(a_no_overflow, clk, rst, full, !do_push)
  `DMA_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, count <= 2'(QDepth))
  `DMA_ASSERT_NEXT(a_pop_drops, clk, rst, do_pop && !do_push, count == $past(count) - 2'd1)
endmodule

@@ design/dmaotc_back.sv @@
// Back part: register file and transfer engine, one transaction per cycle while the result register is free or popped.
module dmaotc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  dmaotc_pkg::op_t        op,
  input  logic                   op_valid,
  output logic                   op_take,
  output dmaotc_pkg::out_item_t  out_item,
  output logic                   empty,
  input  logic                   pop
);
  import dmaotc_pkg::*;

  logic [31:0]         regs [NRegs];
  mode_t               mode;
  logic [AddrBits-1:0] cur;
  logic [31:0]         remain;
  logic                rpend;
  logic                inpay;
  logic [AddrBits-1:0] link;
  logic                lend;
  logic                ovalid;
  out_item_t           res;

  logic                fire;
  logic                ctl_we;
  logic [4:0]          ctl_idx;
  logic [31:0]         ctl_val;
  logic                reg_we;
  logic [31:0]         prod;
  logic                pfin;

  mode_t               mode_next;
  logic [AddrBits-1:0] cur_next;
  logic [31:0]         remain_next;
  logic                rpend_next;
  logic                inpay_next;
  logic [AddrBits-1:0] link_next;
  logic                lend_next;
  out_item_t           res_next;

  logic [2:0]          ch;
  logic [31:0]         c_new;
  logic [31:0]         base_w;
  logic [31:0]         cnt_w;
  logic [4:0]          fin_idx;

  assign op_take = !ovalid || pop;
  assign fire = op_valid && op_take;
  assign empty = !ovalid;
  assign out_item = res;
  assign ch = op.idx[4:2];
  assign prod = {16'd0, cnt_w[15:0]} * {16'd0, cnt_w[31:16]};

  // Work out the result and the next engine state.
  always_comb begin
    mode_next = mode;
    cur_next = cur;
    remain_next = remain;
    rpend_next = rpend;
    inpay_next = inpay;
    link_next = link;
    lend_next = lend;
    res_next = '0;
    reg_we = 1'b0;
    ctl_we = 1'b0;
    ctl_idx = 5'd0;
    ctl_val = '0;
    pfin = 1'b0;
    c_new = (op.idx[1:0] == 2'd2) ? op.wdata : regs[{ch, 2'd2}];
    base_w = (op.idx[1:0] == 2'd0) ? op.wdata : regs[{ch, 2'd0}];
    cnt_w = (op.idx[1:0] == 2'd1) ? op.wdata : regs[{ch, 2'd1}];
    fin_idx = (mode == M_OTC) ? 5'd26 : 5'd10;
    case (op.cmd)
      CMD_WRITE: begin
        if (mode != M_IDLE) begin
          res_next.kind = K_BUSY;
        end else begin
          res_next.kind = K_WOK;
          if (op.idx_ok) begin
            reg_we = 1'b1;
            if (ch < 3'(Channels) && c_new[24] && (c_new[28] || c_new[10:9] != 2'd0)) begin
              if (ch == 3'd6 && c_new == CtlOtc) begin
                mode_next = M_OTC;
                cur_next = base_w[AddrBits-1:0];
                remain_next = (cnt_w != 32'd0) ? cnt_w : 32'd1;
              end else if (ch == 3'd2 && c_new == CtlSeq) begin
                mode_next = M_SEQ;
                cur_next = base_w[AddrBits-1:0];
                remain_next = (prod != 32'd0) ? prod : 32'd1;
                rpend_next = 1'b0;
              end else if (ch == 3'd2 && c_new == CtlList) begin
                mode_next = M_LIST;
                cur_next = base_w[AddrBits-1:0];
                remain_next = 32'd0;
                rpend_next = 1'b0;
                inpay_next = 1'b0;
                lend_next = 1'b0;
                link_next = '0;
              end else begin
                res_next.kind = K_BAD;
                res_next.data_out = c_new;
                ctl_we = 1'b1;
                ctl_idx = {ch, 2'd2};
                ctl_val = c_new & ~(BitBusy | BitTrig);
              end
            end
          end
        end
      end
      CMD_READ: begin
        res_next.kind = K_READ;
        res_next.data_out = op.idx_ok ? regs[op.idx] : 32'd0;
      end
      CMD_TICK: begin
        if (mode == M_IDLE || rpend) begin
          res_next.kind = K_IDLE;
        end else if (mode == M_OTC) begin
          res_next.kind = K_MWR;
          res_next.mem_address = cur;
          if (remain <= 32'd1) begin
            res_next.data_out = OtcEnd;
            pfin = 1'b1;
          end else begin
            remain_next = remain - 32'd1;
            cur_next = cur - AddrBits'(4);
            res_next.data_out = {{(32-AddrBits){1'b0}}, cur - AddrBits'(4)};
          end
        end else begin
          rpend_next = 1'b1;
          res_next.kind = K_MREQ;
          res_next.mem_address = cur;
        end
      end
      default: begin
        if (mode == M_IDLE || !rpend) begin
          res_next.kind = K_UNEXP;
        end else begin
          rpend_next = 1'b0;
          res_next.mem_address = cur;
          res_next.data_out = op.mdata;
          if (mode == M_SEQ) begin
            res_next.kind = K_GPU;
            remain_next = remain - 32'd1;
            cur_next = cur + AddrBits'(4);
            pfin = remain == 32'd1;
          end else if (!inpay) begin
            res_next.kind = K_HDR;
            link_next = op.mdata[AddrBits-1:0];
            lend_next = op.mdata[23];
            if (op.mdata[31:24] == 8'd0) begin
              if (op.mdata[23]) pfin = 1'b1;
              else cur_next = op.mdata[AddrBits-1:0];
            end else begin
              inpay_next = 1'b1;
              remain_next = {24'd0, op.mdata[31:24]};
              cur_next = cur + AddrBits'(4);
            end
          end else begin
            res_next.kind = K_GPU;
            remain_next = remain - 32'd1;
            cur_next = cur + AddrBits'(4);
            if (remain == 32'd1) begin
              inpay_next = 1'b0;
              if (lend) pfin = 1'b1;
              else cur_next = link;
            end
          end
        end
      end
    endcase
    // Finish: clear start bits and drop back to idle.
    if (pfin) begin
      res_next.transfer_done = 1'b1;
      mode_next = M_IDLE;
      rpend_next = 1'b0;
      inpay_next = 1'b0;
      lend_next = 1'b0;
      ctl_we = 1'b1;
      ctl_idx = fin_idx;
      ctl_val = regs[fin_idx] & ~(BitBusy | BitTrig);
    end
  end

  // Update the register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NRegs; i++) begin
        regs[i] <= (i == Channels * 4) ? PrioReset : 32'd0;
      end
    end else if (fire) begin
      if (reg_we) regs[op.idx] <= op.wdata;
      if (ctl_we) regs[ctl_idx] <= ctl_val;
    end
  end

  // Advance engine state and hold the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      cur <= '0;
      remain <= '0;
      rpend <= 1'b0;
      inpay <= 1'b0;
      link <= '0;
      lend <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (fire) begin
        mode <= mode_next;
        cur <= cur_next;
        remain <= remain_next;
        rpend <= rpend_next;
        inpay <= inpay_next;
        link <= link_next;
        lend <= lend_next;
        res <= res_next;
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  `include "dma_controller_otc_and_linked_list_macros.svh"
  `DMA_ASSERT_IMP(a_idle_no_pend, clk, rst, mode == M_IDLE, !rpend && !inpay)
  `DMA_ASSERT_NEXT(a_done_idle, clk, rst, fire && pfin, mode == M_IDLE)
  `DMA_ASSERT_NEXT(a_hold, clk, rst, ovalid && !pop, ovalid && $stable(res))
endmodule
